// ===== rtl/core/wmmf_pkg.sv =====
`default_nettype none

package wmmf_pkg;

  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned LEN_W          = 4;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 4;
  localparam int unsigned SUM_W          = SAMPLE_W + LEN_W;
  localparam int unsigned WINDOW_MAX_DEF = 10;

  localparam logic [MODE_W-1:0] MODE_PASS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MEAN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MEDIAN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN  = 1'd1;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_MEAN;
  localparam logic [LEN_W-1:0]  LEN_RESET  = 4'd5;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shf;
  } sort_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/windowed_mean_median_filter_core.sv =====
// Windowed mean / median filter.
// Input channel: sample_i with in_valid_i / in_ready_o. Output channel:
// filtered_o and window_full_o with out_valid_o / out_ready_i. Every request
// gives exactly one result, in order. Configuration: cfg_we_i writes
// cfg_data_i into register cfg_idx_i (0 mode, 1 window length) at once and
// clears the window; write only while the block is idle.
// Samples go into a ring in a single-port-write RAM. Until the window has
// filled, and in pass-through or unknown mode, the request goes straight to
// the emit state. Mean: the window is read back one entry per cycle from the
// registered RAM output and summed, then a bit-serial divider forms the
// quotient. Median: the same read-back feeds an insertion row, then the row
// shifts down to the middle entry (middle pair averaged for even lengths).
// One request is in flight at a time; the next is taken as soon as the
// result sits in the output register, even if the receiver stalls. A
// stalled receiver holds the result and blocks the following request only
// when its result is also finished.
// Reset: mode mean, length 5, window empty; no clearing pass is needed.
`default_nettype none

module windowed_mean_median_filter_core import wmmf_pkg::*; #(
  parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [SAMPLE_W-1:0]   filtered_o,
  output logic                       window_full_o
);

  localparam int unsigned PTR_W  = $clog2(WINDOW_MAX);
  localparam int unsigned FILL_W = $clog2(WINDOW_MAX + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_LAST  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  logic [2:0]          state_q;
  logic [MODE_W-1:0]   mode_q;
  logic [LEN_W-1:0]    wl_q;
  logic [PTR_W-1:0]    wp_q, rd_idx_q;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                rd_vld_q;
  logic [LEN_W-1:0]    shcnt_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [SAMPLE_W-1:0] res_q;
  logic                full_q;
  logic                out_valid_q, out_full_q;
  logic [SAMPLE_W-1:0] out_filt_q;

  logic [LEN_W-1:0]    len_eff, med_m, med_shift;
  logic                accept, full_d, filt_on, out_free;
  logic [SAMPLE_W-1:0] rd_data, lo, hi;
  logic [SAMPLE_W:0]   mid_sum;
  logic                div_start, div_done;
  logic [SUM_W-1:0]    quotient;
  sort_ctrl_t          sort_ctrl;

  assign len_eff = (wl_q == '0 || wl_q > LEN_W'(WINDOW_MAX)) ? LEN_W'(1) : wl_q;
  assign accept  = in_valid_i && in_ready_o;
  assign fill_d  = (LEN_W'(fill_q) < len_eff) ? fill_q + FILL_W'(1) : fill_q;
  assign full_d  = LEN_W'(fill_d) == len_eff;
  assign filt_on = mode_q == MODE_MEAN || mode_q == MODE_MEDIAN;
  assign sum_d   = sum_q + SUM_W'(rd_data);
  assign out_free = !out_valid_q || out_ready_i;

  assign med_m     = len_eff >> 1;
  assign med_shift = len_eff[0] ? med_m : med_m - LEN_W'(1);
  assign mid_sum   = {1'b0, lo} + {1'b0, (len_eff[0] ? lo : hi)};

  assign div_start = state_q == ST_LAST && mode_q == MODE_MEAN;

  assign sort_ctrl.clr = accept;
  assign sort_ctrl.ins = rd_vld_q;
  assign sort_ctrl.shf = state_q == ST_SHIFT && shcnt_q != '0;

  wmmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (wp_q),
    .wdata_i (sample_i),
    .raddr_i (rd_idx_q),
    .rdata_o (rd_data)
  );

  wmmf_sorter #(
    .DEPTH (WINDOW_MAX)
  ) u_sorter (
    .clk_i  (clk_i),
    .ctrl_i (sort_ctrl),
    .data_i (rd_data),
    .lo_o   (lo),
    .hi_o   (hi)
  );

  wmmf_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (len_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_RESET;
      wl_q        <= LEN_RESET;
      wp_q        <= '0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      shcnt_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= state_q == ST_READ;
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
          REG_LEN:  wl_q   <= cfg_data_i[LEN_W-1:0];
          default:  ;
        endcase
        wp_q   <= '0;
        fill_q <= '0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            fill_q   <= fill_d;
            wp_q     <= (LEN_W'(wp_q) == len_eff - LEN_W'(1)) ? '0 : wp_q + PTR_W'(1);
            rd_idx_q <= '0;
            state_q  <= (full_d && filt_on) ? ST_READ : ST_EMIT;
          end
        end
        ST_READ: begin
          if (LEN_W'(rd_idx_q) == len_eff - LEN_W'(1)) begin
            state_q <= ST_LAST;
          end else begin
            rd_idx_q <= rd_idx_q + PTR_W'(1);
          end
        end
        ST_LAST: begin
          shcnt_q <= med_shift;
          state_q <= (mode_q == MODE_MEAN) ? ST_DIV : ST_SHIFT;
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_EMIT;
          end
        end
        ST_SHIFT: begin
          if (shcnt_q == '0) begin
            state_q <= ST_EMIT;
          end else begin
            shcnt_q <= shcnt_q - LEN_W'(1);
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q  <= sample_i;
      full_q <= full_d;
      sum_q  <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_d;
    end
    if (state_q == ST_DIV && div_done) begin
      res_q <= quotient[SAMPLE_W-1:0];
    end
    if (state_q == ST_SHIFT && shcnt_q == '0) begin
      res_q <= mid_sum[SAMPLE_W:1];
    end
    if (state_q == ST_EMIT && out_free) begin
      out_filt_q <= res_q;
      out_full_q <= full_q;
    end
  end

  assign in_ready_o    = state_q == ST_IDLE;
  assign out_valid_o   = out_valid_q;
  assign filtered_o    = out_filt_q;
  assign window_full_o = out_full_q;

`ifndef NO_ASSERTIONS
  a_wp_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(wp_q) < len_eff)
    else $error("write position outside window");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(fill_q) <= len_eff)
    else $error("fill count above window length");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside divide state");

  a_rd_vld_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_READ || state_q == ST_LAST))
    else $error("ring read data arrived outside read phase");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/wmmf_ram.sv =====
`default_nettype none

module wmmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/wmmf_sorter.sv =====
`default_nettype none

module wmmf_sorter import wmmf_pkg::*; #(
  parameter int unsigned DEPTH = WINDOW_MAX_DEF
) (
  input  wire logic                clk_i,
  input  wire sort_ctrl_t          ctrl_i,
  input  wire logic [SAMPLE_W-1:0] data_i,
  output logic      [SAMPLE_W-1:0] lo_o,
  output logic      [SAMPLE_W-1:0] hi_o
);

  // ascending row, unused slots hold all ones
  logic [SAMPLE_W-1:0] row_q [DEPTH];
  logic [SAMPLE_W-1:0] row_ins [DEPTH];
  logic [DEPTH-1:0]    gt;

  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      gt[k] = row_q[k] > data_i;
    end
    row_ins[0] = gt[0] ? data_i : row_q[0];
    for (int k = 1; k < DEPTH; k++) begin
      if (!gt[k]) begin
        row_ins[k] = row_q[k];
      end else if (!gt[k-1]) begin
        row_ins[k] = data_i;
      end else begin
        row_ins[k] = row_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clr) begin
      for (int k = 0; k < DEPTH; k++) begin
        row_q[k] <= '1;
      end
    end else if (ctrl_i.ins) begin
      for (int k = 0; k < DEPTH; k++) begin
        row_q[k] <= row_ins[k];
      end
    end else if (ctrl_i.shf) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        row_q[k] <= row_q[k+1];
      end
      row_q[DEPTH-1] <= '1;
    end
  end

  assign lo_o = row_q[0];
  assign hi_o = row_q[1];

endmodule

`default_nettype wire

// ===== rtl/core/wmmf_div.sv =====
`default_nettype none

module wmmf_div #(
  parameter int unsigned DIVIDEND_W = 20,
  parameter int unsigned DIVISOR_W  = 4
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic      [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q, done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, dvs_q;
  logic [DIVISOR_W:0]    trial, diff;
  logic                  take;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign take  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], take};
      rem_q <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== test/filter_output_checker.sv =====
module filter_output_checker import wmmf_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_ready_i,
  input  wire logic [SAMPLE_W-1:0]   sample_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_ready_i,
  input  wire logic [SAMPLE_W-1:0]   filtered_i,
  input  wire logic                  window_full_i,
  output int unsigned                errors_o,
  output int unsigned                pending_o,
  output int unsigned                checked_o,
  output int unsigned                full_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] filtered;
    logic                full;
  } filter_out_t;

  logic [MODE_W-1:0]   mode;
  logic [LEN_W-1:0]    wlen;
  logic [SAMPLE_W-1:0] ring [WINDOW_MAX_DEF];
  logic [LEN_W-1:0]    wpos;
  logic [LEN_W-1:0]    fill;
  filter_out_t         pending_outputs [$];

  function automatic void clear_window();
    for (int k = 0; k < WINDOW_MAX_DEF; k++) ring[k] = '0;
    wpos = '0;
    fill = '0;
  endfunction

  function automatic int unsigned window_span();
    if (wlen == 0 || wlen > WINDOW_MAX_DEF) return 1;
    return wlen;
  endfunction

  // advances the window by one sample and returns the filter output
  function automatic filter_out_t filter_sample(input logic [SAMPLE_W-1:0] raw);
    int unsigned         len;
    int                  i;
    int                  j;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W:0]   pair;
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] srt [WINDOW_MAX_DEF];
    filter_out_t         res;
    len = window_span();
    if (wpos >= len) wpos = '0;
    ring[wpos] = raw;
    wpos = LEN_W'((wpos + 1) % len);
    if (fill < len) fill = fill + 1'b1;
    res.raw = raw;
    res.filtered = raw;
    res.full = 1'b0;
    if (fill < len) return res;
    res.full = 1'b1;
    if (mode == MODE_MEAN) begin
      sum = '0;
      for (i = 0; i < len; i++) sum = sum + ring[i];
      res.filtered = SAMPLE_W'(sum / len);
    end else if (mode == MODE_MEDIAN) begin
      for (i = 0; i < len; i++) begin
        x = ring[i];
        j = i;
        while (j > 0 && srt[j-1] > x) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = x;
      end
      if (len % 2 == 1) begin
        res.filtered = srt[len/2];
      end else begin
        pair = {1'b0, srt[len/2-1]} + {1'b0, srt[len/2]};
        res.filtered = pair[SAMPLE_W:1];
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    filter_out_t want;
    if (!rst_ni) begin
      mode = MODE_RESET;
      wlen = LEN_RESET;
      clear_window();
      pending_outputs.delete();
      errors_o = 0;
      checked_o = 0;
      full_results_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_outputs.size() == 0) begin
          errors_o++;
          if (errors_o <= MAX_REPORTS)
            $display("%0t: unexpected result filtered %h window_full %b",
                     $time, filtered_i, window_full_i);
        end else begin
          want = pending_outputs.pop_front();
          checked_o++;
          if (want.full) full_results_o++;
          if (filtered_i !== want.filtered || window_full_i !== want.full) begin
            errors_o++;
            if (errors_o <= MAX_REPORTS)
              $display("%0t: sample %h: expected filtered %h window_full %b, got %h %b",
                       $time, want.raw, want.filtered, want.full, filtered_i,
                       window_full_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) pending_outputs.push_back(filter_sample(sample_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE: mode = cfg_data_i[MODE_W-1:0];
          REG_LEN:  wlen = cfg_data_i[LEN_W-1:0];
          default: ;
        endcase
        clear_window();
      end
      pending_o = pending_outputs.size();
    end
  end

endmodule

// ===== test/windowed_mean_median_filter_core_tb.sv =====
module windowed_mean_median_filter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmmf_pkg::*;

  localparam int unsigned SAMPLE_TARGET = 1800;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [SAMPLE_W-1:0]   sample_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [SAMPLE_W-1:0]   filtered_o;
  logic                  window_full_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned full_hits;
  int unsigned samples_sent;
  int unsigned reg_writes;
  int unsigned cycle_count;
  int unsigned ready_hold;
  bit          dense;

  windowed_mean_median_filter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .filtered_o   (filtered_o),
    .window_full_o(window_full_o)
  );

  filter_output_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .sample_i      (sample_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .filtered_i    (filtered_o),
    .window_full_i (window_full_o),
    .errors_o      (errors),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_results_o(full_hits)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** windowed_mean_median_filter_core: FAILED **");
      $finish;
    end
  end

  // receiver: short stalls, long stalls and long stall-free stretches
  always @(posedge clk_i) begin
    int unsigned roll;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        out_ready_i <= 1'b1;
        ready_hold <= $urandom_range(0, 7);
      end else if (roll < 60) begin
        out_ready_i <= 1'b1;
        ready_hold <= $urandom_range(50, 200);
      end else if (roll < 90) begin
        out_ready_i <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b0;
        ready_hold <= $urandom_range(10, 60);
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (dense) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // base gives clustered values so the median sees ties
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] base);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return SAMPLE_W'($urandom_range(0, 15));
      3:       return SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
      4, 5:    return SAMPLE_W'(base + $urandom_range(0, 3));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_length();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return CFG_DATA_W'(1);
        2:       return CFG_DATA_W'(2);
        3:       return CFG_DATA_W'(WINDOW_MAX_DEF);
        4:       return CFG_DATA_W'(WINDOW_MAX_DEF + 1);
        default: return '1;
      endcase
    end
    return CFG_DATA_W'($urandom_range(1, WINDOW_MAX_DEF));
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input int unsigned gap);
    bit taken;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= value;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    samples_sent++;
  endtask

  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  initial begin
    int unsigned         span;
    int unsigned         choice;
    logic [SAMPLE_W-1:0] base;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MODE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    out_ready_i = 1'b0;
    ready_hold = 0;
    cycle_count = 0;
    samples_sent = 0;
    reg_writes = 0;
    dense = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: mean over five, full-scale sum
    repeat (5) send_sample(16'hFFFF, 0);
    send_sample(16'h0000, 0);
    send_sample(16'h0001, 2);

    // even median, middle pair at full scale
    drain_outputs();
    write_reg(REG_MODE, {2'b11, MODE_MEDIAN});
    write_reg(REG_LEN, CFG_DATA_W'(4));
    send_sample(16'hFFFF, 0);
    send_sample(16'hFFFF, 1);
    send_sample(16'h0001, 0);
    send_sample(16'h0000, 0);
    send_sample(16'hFFFF, 3);
    send_sample(16'hFFFF, 0);
    send_sample(16'hFFFF, 0);

    // zero length acts as one
    drain_outputs();
    write_reg(REG_LEN, '0);
    write_reg(REG_MODE, {2'b01, MODE_PASS});
    send_sample(16'hA5A5, 0);
    send_sample(16'h5A5A, 0);

    // unknown mode, oversized length
    drain_outputs();
    write_reg(REG_MODE, {2'b10, MODE_OTHER});
    write_reg(REG_LEN, '1);
    send_sample(16'h8000, 0);
    send_sample(16'h7FFF, 1);

    drain_outputs();
    write_reg(REG_LEN, CFG_DATA_W'(2));
    send_sample(16'h0000, 0);
    send_sample(16'hFFFF, 0);
    send_sample(16'h1234, 0);

    while (samples_sent < SAMPLE_TARGET) begin
      choice = $urandom_range(0, 9);
      if (choice < 8) begin
        drain_outputs();
        if (choice < 3) begin
          write_reg(REG_MODE, CFG_DATA_W'($urandom));
        end else if (choice < 5) begin
          write_reg(REG_LEN, pick_length());
        end else begin
          write_reg(REG_LEN, pick_length());
          write_reg(REG_MODE, CFG_DATA_W'($urandom));
        end
      end
      dense = ($urandom_range(0, 3) == 0);
      base = SAMPLE_W'($urandom);
      span = ($urandom_range(0, 19) == 0) ? $urandom_range(80, 150) : $urandom_range(4, 40);
      repeat (span) begin
        if ($urandom_range(0, 59) == 0) drain_outputs();
        send_sample(pick_sample(base), pick_gap());
      end
    end

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("%0d samples in %0d cycles, %0d register writes across modes and lengths",
             samples_sent, cycle_count, reg_writes);
    $display("%0d filtered results checked, %0d on a full window", checked, full_hits);
    if (errors == 0 && pending == 0) begin
      $display("** windowed_mean_median_filter_core: PASSED **");
    end else begin
      $display("** windowed_mean_median_filter_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== windowed_mean_median_filter_core.f =====
rtl/core/wmmf_pkg.sv
rtl/core/wmmf_ram.sv
rtl/core/wmmf_sorter.sv
rtl/core/wmmf_div.sv
rtl/core/windowed_mean_median_filter_core.sv
test/filter_output_checker.sv
test/windowed_mean_median_filter_core_tb.sv
